// ===== src/mse_pkg.sv =====
// Shared types, opcodes and constants for the MIPS32 subset execute core.
// No dependencies.
`default_nettype none
package mse_pkg;
  localparam logic [31:0] PcRegionMask = 32'hF000_0000;
  localparam logic [31:0] DefaultResetPc = 32'h0000_1000;
  localparam logic [4:0]  LinkReg = 5'd31;
  localparam int          LuiShift = 16;
  localparam int          NumRegs = 32;
  localparam int          RegIdxW = $clog2(NumRegs);
  localparam int          QDepth = 2;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LB   = 2'd1,
    PEND_LBU  = 2'd2,
    PEND_LW   = 2'd3
  } pend_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_e;

  localparam logic [5:0] OpSpecial = 6'h00, OpJ = 6'h02, OpJal = 6'h03, OpBeq = 6'h04,
    OpBne = 6'h05, OpAddiu = 6'h09, OpSlti = 6'h0A, OpSltiu = 6'h0B, OpAndi = 6'h0C,
    OpOri = 6'h0D, OpXori = 6'h0E, OpLui = 6'h0F, OpLb = 6'h20, OpLw = 6'h23,
    OpLbu = 6'h24, OpSb = 6'h28, OpSw = 6'h2B;
  localparam logic [5:0] FnSll = 6'h00, FnSrl = 6'h02, FnSra = 6'h03, FnJr = 6'h08,
    FnJalr = 6'h09, FnSyscall = 6'h0C, FnMfhi = 6'h10, FnMflo = 6'h12, FnMult = 6'h18,
    FnMultu = 6'h19, FnAddu = 6'h21, FnSubu = 6'h23, FnAnd = 6'h24, FnOr = 6'h25,
    FnXor = 6'h26, FnNor = 6'h27, FnSlt = 6'h2A, FnSltu = 6'h2B;

  // One queued input beat.
  typedef struct packed {
    logic        kind;
    logic [31:0] instr_word;
    logic [31:0] load_data;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_request;
    logic        mem_width;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        syscall_event;
    logic [31:0] syscall_code;
    logic [31:0] syscall_arg;
    logic        illegal;
  } res_t;
endpackage
`default_nettype wire

// ===== src/mips32_subset_execute_core.sv =====
// Top level of the MIPS32 subset execute core.
// Depends on mse_pkg, mse_front and mse_back.
//
// Input channel (in_valid_i/in_stall_o) carries one beat per item: kind 0
// executes instr_word fetched at the current pc, kind 1 returns the data of
// the pending load. Output channel (out_valid_o/out_stall_i) returns one
// result beat per item: next fetch pc, memory request, syscall event and an
// illegal flag. A beat moves when valid is high and stall is low.
// An input beat passes through the two-entry input queue, then through the
// execute stage into the result register.
// Throughput is one item per cycle while the receiver does not stall; the
// execute stage reads and writes the register file in the same step.
// When the receiver stalls, the result register holds; the queue takes up to
// two more beats before in_stall_o rises.
// Reset clears registers, hi, lo and the pending load, and sets the pc to
// 0x1000. A cfg beat (cfg_valid_i/cfg_ready_o) loads cfg_data_i into the pc;
// write it only while the core is idle.
`default_nettype none
module mips32_subset_execute_core import mse_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         kind_i,
  input  wire  [31:0] instr_word_i,
  input  wire  [31:0] load_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_request_o,
  output logic        mem_width_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] mem_wdata_o,
  output logic        syscall_event_o,
  output logic [31:0] syscall_code_o,
  output logic [31:0] syscall_arg_o,
  output logic        illegal_o
);
  item_t in_item, q_item;
  logic  q_valid, q_pop;
  res_t  res;

  assign cfg_ready_o = 1'b1;
  assign in_item = '{kind: kind_i, instr_word: instr_word_i, load_data: load_data_i};

  mse_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  mse_back u_back (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_data_i,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .out_res_o(res)
  );

  assign next_pc_o       = res.next_pc;
  assign mem_request_o   = res.mem_request;
  assign mem_width_o     = res.mem_width;
  assign mem_addr_o      = res.mem_addr;
  assign mem_wdata_o     = res.mem_wdata;
  assign syscall_event_o = res.syscall_event;
  assign syscall_code_o  = res.syscall_code;
  assign syscall_arg_o   = res.syscall_arg;
  assign illegal_o       = res.illegal;
endmodule
`default_nettype wire

// ===== src/mse_front.sv =====
// Front part: accepts input beats into a short queue.
// Depends on mse_pkg.
`default_nettype none
module mse_front import mse_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  wire   q_pop_i
);
  localparam int PtrW = $clog2(QDepth);
  item_t           mem_q [QDepth];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;

  assign in_stall_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    rd_d  = (q_pop_i && q_valid_o) ? rd_q + 1'b1 : rd_q;
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i && q_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      rd_q <= rd_d; wr_q <= wr_d; cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PtrW+1)'(QDepth))
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_i && q_valid_o && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count lost a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid_o) else $error("stall with empty queue");
endmodule
`default_nettype wire

// ===== src/mse_back.sv =====
// Back part: executes queued items against the architectural state.
// Depends on mse_pkg.
`default_nettype none
module mse_back import mse_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output res_t        out_res_o
);
  logic [31:0] regs_q [NumRegs];
  logic [31:0] pc_q, hi_q, lo_q;
  logic [RegIdxW-1:0] pdest_q, pdest_d;
  pend_e       ptype_q, ptype_d;
  logic        ov_q;
  res_t        res_q, res;
  logic        wen;
  logic [RegIdxW-1:0] widx;
  logic [31:0] wval;
  logic        mwe, msig;
  logic [63:0] prod;
  logic [31:0] mhi;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, a, b, npc4, jt, bt, ld;
  logic        bad;

  // Result register is free when empty or being taken.
  assign q_pop_o     = q_valid_i && (!ov_q || !out_stall_i);
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  assign op   = q_item_i.instr_word[31:26];
  assign rs   = q_item_i.instr_word[25:21];
  assign rt   = q_item_i.instr_word[20:16];
  assign rd   = q_item_i.instr_word[15:11];
  assign sh   = q_item_i.instr_word[10:6];
  assign fn   = q_item_i.instr_word[5:0];
  assign imm  = {16'd0, q_item_i.instr_word[15:0]};
  assign simm = {{16{q_item_i.instr_word[15]}}, q_item_i.instr_word[15:0]};
  assign a    = (rs == '0) ? 32'd0 : regs_q[rs];
  assign b    = (rt == '0) ? 32'd0 : regs_q[rt];
  assign npc4 = pc_q + 32'd4;
  assign jt   = (npc4 & PcRegionMask) | {q_item_i.instr_word[25:0], 2'b00};
  assign bt   = npc4 + {simm[29:0], 2'b00};
  assign ld   = q_item_i.load_data;

  // One unsigned product; the signed high word subtracts each operand
  // whose partner is negative.
  assign prod = 64'(a) * 64'(b);
  assign mhi  = prod[63:32] - ((msig && a[31]) ? b : 32'd0)
                            - ((msig && b[31]) ? a : 32'd0);

  // Execute one item.
  always_comb begin
    res = '0;
    res.next_pc = npc4;
    wen = 1'b0; widx = rd; wval = '0; mwe = 1'b0; msig = 1'b0; bad = 1'b0;
    pdest_d = pdest_q; ptype_d = ptype_q;
    if (q_item_i.kind) begin
      res.next_pc = pc_q;
      if (ptype_q == PEND_NONE) bad = 1'b1;
      else begin
        wen = 1'b1; widx = pdest_q;
        case (ptype_q)
          PEND_LB:  wval = {{24{ld[7]}}, ld[7:0]};
          PEND_LBU: wval = {24'd0, ld[7:0]};
          default:  wval = ld;
        endcase
        pdest_d = '0; ptype_d = PEND_NONE;
      end
    end else if (ptype_q != PEND_NONE) begin
      bad = 1'b1;
    end else begin
      case (op)
        OpSpecial: begin
          wen = 1'b1;
          case (fn)
            FnSll:  wval = b << sh;
            FnSrl:  wval = b >> sh;
            FnSra:  wval = $signed(b) >>> sh;
            FnJr:   begin wen = 1'b0; res.next_pc = a; end
            FnJalr: begin wval = npc4; res.next_pc = a; end
            FnSyscall: begin
              wen = 1'b0; res.syscall_event = 1'b1;
              res.syscall_code = regs_q[2]; res.syscall_arg = regs_q[4];
            end
            FnMfhi:  wval = hi_q;
            FnMflo:  wval = lo_q;
            FnMult:  begin wen = 1'b0; mwe = 1'b1; msig = 1'b1; end
            FnMultu: begin wen = 1'b0; mwe = 1'b1; end
            FnAddu:  wval = a + b;
            FnSubu:  wval = a - b;
            FnAnd:   wval = a & b;
            FnOr:    wval = a | b;
            FnXor:   wval = a ^ b;
            FnNor:   wval = ~(a | b);
            FnSlt:   wval = {31'd0, $signed(a) < $signed(b)};
            FnSltu:  wval = {31'd0, a < b};
            default: begin wen = 1'b0; bad = 1'b1; end
          endcase
        end
        OpJ:   res.next_pc = jt;
        OpJal: begin wen = 1'b1; widx = LinkReg; wval = npc4; res.next_pc = jt; end
        OpBeq: if (a == b) res.next_pc = bt;
        OpBne: if (a != b) res.next_pc = bt;
        OpAddiu: begin wen = 1'b1; widx = rt; wval = a + simm; end
        OpSlti:  begin wen = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)}; end
        OpSltiu: begin wen = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
        OpAndi:  begin wen = 1'b1; widx = rt; wval = a & imm; end
        OpOri:   begin wen = 1'b1; widx = rt; wval = a | imm; end
        OpXori:  begin wen = 1'b1; widx = rt; wval = a ^ imm; end
        OpLui:   begin wen = 1'b1; widx = rt; wval = imm << LuiShift; end
        OpLb, OpLw, OpLbu: begin
          res.mem_request = REQ_READ;
          res.mem_width = (op == OpLw);
          res.mem_addr = a + simm;
          pdest_d = rt;
          ptype_d = (op == OpLb) ? PEND_LB : (op == OpLbu) ? PEND_LBU : PEND_LW;
        end
        OpSb, OpSw: begin
          res.mem_request = REQ_WRITE;
          res.mem_width = (op == OpSw);
          res.mem_addr = a + simm;
          res.mem_wdata = b;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) begin
      res = '0; res.next_pc = pc_q; res.illegal = 1'b1;
      wen = 1'b0; mwe = 1'b0; pdest_d = pdest_q; ptype_d = ptype_q;
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= DefaultResetPc; hi_q <= '0; lo_q <= '0;
      pdest_q <= '0; ptype_q <= PEND_NONE; ov_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_data_i;
      else if (q_pop_o) pc_q <= res.next_pc;
      if (q_pop_o) begin
        pdest_q <= pdest_d; ptype_q <= ptype_d;
        if (wen && widx != '0) regs_q[widx] <= wval;
        if (mwe) begin hi_q <= mhi; lo_q <= prod[31:0]; end
      end
      if (q_pop_o) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) res_q <= res;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) regs_q[0] == '0)
    else $error("r0 written");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(res_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptype_q == PEND_NONE) |-> pdest_q == '0) else $error("stale pending dest");
endmodule
`default_nettype wire
